/* src/mcbd_pkg.sv */
`default_nettype none
package mcbd_pkg;

   // timer and tally widths
   localparam int TimerW = 16;
   localparam int TallyW = 4;
   localparam logic [TimerW-1:0] TIMER_MAX = {TimerW{1'b1}};
   localparam logic [TallyW-1:0] TALLY_MAX = {TallyW{1'b1}};
   // click counts up to this start a blackout
   localparam logic [TallyW-1:0] BLACKOUT_TALLY_MAX = TallyW'(4);

   // event codes
   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_CLICKS = 2'd1;
   localparam logic [1:0] EV_LONG   = 2'd2;

   // register indexes
   localparam int CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] CSR_CLICK_GAP  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_COOLDOWN   = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_BLACKOUT   = 2'd3;

   // register reset values
   localparam logic [TimerW-1:0] CLICK_GAP_RST  = 16'd300;
   localparam logic [TimerW-1:0] LONG_PRESS_RST = 16'd5000;
   localparam logic [TimerW-1:0] COOLDOWN_RST   = 16'd500;
   localparam logic [TimerW-1:0] BLACKOUT_RST   = 16'd1100;

   typedef struct packed {
      logic [TimerW-1:0] click_gap_ms;
      logic [TimerW-1:0] long_press_ms;
      logic [TimerW-1:0] cooldown_ms;
      logic [TimerW-1:0] blackout_ms;
   } cfg_type;

   typedef struct packed {
      logic              armed;
      logic [TallyW-1:0] clicks;
      logic [1:0]        event_res;
   } result_type;

endpackage
`default_nettype wire

/* src/mcbd_csr.sv */
`default_nettype none
module mcbd_csr
   import mcbd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [TimerW-1:0]  csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CLICK_GAP:  cfg_in.click_gap_ms  = csr_wdata;
            CSR_LONG_PRESS: cfg_in.long_press_ms = csr_wdata;
            CSR_COOLDOWN:   cfg_in.cooldown_ms   = csr_wdata;
            CSR_BLACKOUT:   cfg_in.blackout_ms   = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.click_gap_ms  <= CLICK_GAP_RST;
         cfg_ff.long_press_ms <= LONG_PRESS_RST;
         cfg_ff.cooldown_ms   <= COOLDOWN_RST;
         cfg_ff.blackout_ms   <= BLACKOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* src/mcbd_core.sv */
`default_nettype none
module mcbd_core
   import mcbd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step,
   input  wire logic pressed,
   input  wire cfg_type cfg,
   output result_type result
);

   logic              last_level_ff, last_level_in;
   logic              holding_ff, holding_in;
   logic              long_done_ff, long_done_in;
   logic              accepting_ff, accepting_in;
   logic [TallyW-1:0] tally_ff, tally_in;
   logic [TimerW-1:0] hold_time_ff, hold_time_in;
   logic [TimerW-1:0] since_release_ff, since_release_in;
   logic [TimerW-1:0] since_event_ff, since_event_in;
   logic [TimerW-1:0] blackout_left_ff, blackout_left_in;

   logic fell;
   logic rose;
   logic long_hit;
   logic click_hit;

   // one tick of the decoder
   always_comb begin
      fell = pressed & ~last_level_ff;
      rose = ~pressed & last_level_ff;
      long_hit = 1'b0;
      click_hit = 1'b0;

      last_level_in    = pressed;
      holding_in       = holding_ff;
      long_done_in     = long_done_ff;
      accepting_in     = accepting_ff;
      tally_in         = tally_ff;
      // free-running timers saturate
      hold_time_in     = (hold_time_ff == TIMER_MAX) ? TIMER_MAX : hold_time_ff + 1'b1;
      since_release_in = (since_release_ff == TIMER_MAX) ? TIMER_MAX
                                                         : since_release_ff + 1'b1;
      since_event_in   = (since_event_ff == TIMER_MAX) ? TIMER_MAX : since_event_ff + 1'b1;
      blackout_left_in = blackout_left_ff;

      result.event_res = EV_NONE;
      result.clicks    = '0;

      if (blackout_left_ff != '0) begin
         // blackout: only follow the level
         blackout_left_in = blackout_left_ff - 1'b1;
      end else begin
         // rearm once released and cooled down
         if (!accepting_ff && !pressed && since_event_in >= cfg.cooldown_ms)
            accepting_in = 1'b1;

         if (accepting_in) begin
            if (fell) begin
               holding_in   = 1'b1;
               hold_time_in = '0;
               long_done_in = 1'b0;
            end

            // long press
            long_hit = holding_in & pressed & ~long_done_in
                       & (hold_time_in >= cfg.long_press_ms);
            if (long_hit) begin
               long_done_in     = 1'b1;
               tally_in         = '0;
               accepting_in     = 1'b0;
               since_event_in   = '0;
               result.event_res = EV_LONG;
            end

            // count a click on release
            if (rose) begin
               if (!long_done_in) begin
                  if (tally_in != TALLY_MAX)
                     tally_in = tally_in + 1'b1;
                  since_release_in = '0;
               end
               holding_in = 1'b0;
            end

            // close the click sequence after the gap
            click_hit = ~holding_in & (tally_in != '0)
                        & (since_release_in >= cfg.click_gap_ms);
            if (click_hit) begin
               result.event_res = EV_CLICKS;
               result.clicks    = tally_in;
               if (tally_in <= BLACKOUT_TALLY_MAX)
                  blackout_left_in = (cfg.blackout_ms != '0) ? cfg.blackout_ms - 1'b1 : '0;
               tally_in       = '0;
               accepting_in   = 1'b0;
               since_event_in = '0;
            end
         end
      end

      result.armed = accepting_in;
   end

   // advance state on each tick taken
   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff    <= 1'b0;
         holding_ff       <= 1'b0;
         long_done_ff     <= 1'b0;
         accepting_ff     <= 1'b1;
         tally_ff         <= '0;
         hold_time_ff     <= '0;
         since_release_ff <= '0;
         since_event_ff   <= '0;
         blackout_left_ff <= '0;
      end else if (step) begin
         last_level_ff    <= last_level_in;
         holding_ff       <= holding_in;
         long_done_ff     <= long_done_in;
         accepting_ff     <= accepting_in;
         tally_ff         <= tally_in;
         hold_time_ff     <= hold_time_in;
         since_release_ff <= since_release_in;
         since_event_ff   <= since_event_in;
         blackout_left_ff <= blackout_left_in;
      end
   end

endmodule
`default_nettype wire

/* src/multi_click_button_decoder_top.sv */
// An accepted req word passes the input register, then the result register, before
// its rsp word leaves; the decoder state advances once per word.
// Throughput: one word per cycle unless a low rsp_tready stalls the output.
// Reset: synchronous, active high; registers return to their default values,
// the decoder is armed and both pipeline stages are empty.
`default_nettype none
module multi_click_button_decoder_top
   import mcbd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // req_tdata: [0] pressed, [7:1] zero
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,
   // rsp_tdata: [1:0] event_res, [5:2] clicks, [6] armed, [7] zero
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,
   input  wire logic               csr_we,
   input  wire logic [CsrIdxW-1:0] csr_index,
   input  wire logic [TimerW-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic       in_pressed_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   logic       out_open;
   logic       step;

   mcbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mcbd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .pressed (in_pressed_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // pipeline handshake
   assign out_open     = ~out_valid_ff | rsp_tready;
   assign step         = in_valid_ff & out_open;
   assign req_tready   = ~in_valid_ff | step;
   assign in_valid_in  = (req_tvalid & req_tready) | (in_valid_ff & ~step);
   assign out_valid_in = step | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // capture input word and result word
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready)
         in_pressed_ff <= req_tdata[0];
      if (step)
         out_data_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff.armed, out_data_ff.clicks, out_data_ff.event_res};

endmodule
`default_nettype wire
